// ----- design/trmt_pkg.sv -----
package trmt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam logic [39:0] HOLD_RESET = 40'd20000000000;
    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_SAVE   = 2'd1;
    localparam logic [1:0] FUNC_MATCH  = 2'd2;
    localparam logic [1:0] FUNC_EXPIRE = 2'd3;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_SAVED   = 3'd2;
    localparam logic [2:0] ST_EVICTED = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] peer_address;
        logic [63:0] seq_number;
        logic [15:0] packet_index;
        logic [62:0] now;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] result_index;
        logic [2:0]  status;
    } out_beat_t;

endpackage

// ----- design/timed_request_match_table_core.sv -----
// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+------------------------
// in        | input     | in_valid/in_stall | in_beat_t (func, key, now)
// out       | output    | out_valid/out_stall | out_beat_t (index, status)
// cfg       | input     | cfg_we            | hold_time, 40 bits
//
// result is valid after the accepting edge once the single table read port has scanned
// every slot, one slot per cycle, then drained and decided; a save that evicts adds
// the scan2 and drain2 steps for the table write. in_stall drops as the result rises.
// reset clears valid bits and used count at once.
// in_stall is high from the accepting edge until the result moves to the output
// register, which waits while an earlier result is held by out_stall.
module timed_request_match_table_core
    import trmt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat,
    input  logic      cfg_we,
    input  logic [39:0] cfg_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_SCAN2, S_DRAIN2, S_OUT}
        state_t;

    // table memory: one read port, scanned one slot per cycle
    logic [31:0] mem_peer [DEPTH];
    logic [63:0] mem_seq  [DEPTH];
    logic [15:0] mem_pkt  [DEPTH];
    logic [62:0] mem_dl   [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    state_t      state_reg;
    in_beat_t    req_reg;
    logic [39:0] hold_reg;
    logic [CW-1:0] used_reg;
    logic [AW-1:0] addr_reg;     // read address
    logic [AW-1:0] raddr_reg;    // address of data now on read regs
    logic          rd_ok_reg;    // read regs hold a scanned slot
    logic [31:0] rd_peer_reg;
    logic [63:0] rd_seq_reg;
    logic [15:0] rd_pkt_reg;
    logic [62:0] rd_dl_reg;
    // key match result
    logic          hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic [15:0]   hit_pkt_reg;
    // earliest deadline result
    logic          best_reg;
    logic [AW-1:0] best_slot_reg;
    logic [62:0]   best_dl_reg;
    logic [15:0]   best_pkt_reg;
    // lowest free slot
    logic          free_ok_reg;
    logic [AW-1:0] free_slot_reg;
    out_beat_t     res_reg;      // result waiting for the output register
    out_beat_t     out_reg;
    logic          out_valid_reg;

    logic          wr_en;
    logic [AW-1:0] wr_slot;
    logic [63:0]   dl_sum;
    logic [62:0]   dl_sat;
    logic          rd_valid;
    logic          key_eq;
    logic          earlier;

    assign dl_sum   = {1'b0, req_reg.now} + {24'd0, hold_reg};
    assign dl_sat   = dl_sum[63] ? TIME_MAX : dl_sum[62:0];
    assign rd_valid = rd_ok_reg && valid_reg[raddr_reg];
    assign key_eq   = (rd_peer_reg == req_reg.peer_address) && (rd_seq_reg == req_reg.seq_number);
    assign earlier  = !best_reg || (rd_dl_reg < best_dl_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // table write happens in the decide step, and in the drain2 step of an evicting save
    assign wr_en   = (state_reg == S_DECIDE) && (req_reg.func == FUNC_SAVE) && !hit_reg
                     && (used_reg != CW'(DEPTH));
    assign wr_slot = free_slot_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en || state_reg == S_DRAIN2)
        begin
            mem_peer[wr_slot] <= req_reg.peer_address;
            mem_seq[wr_slot]  <= req_reg.seq_number;
            mem_pkt[wr_slot]  <= req_reg.packet_index;
            mem_dl[wr_slot]   <= dl_sat;
        end
        rd_peer_reg <= mem_peer[addr_reg];
        rd_seq_reg  <= mem_seq[addr_reg];
        rd_pkt_reg  <= mem_pkt[addr_reg];
        rd_dl_reg   <= mem_dl[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            hold_reg      <= HOLD_RESET;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                hold_reg <= cfg_data;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            raddr_reg <= addr_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg     <= in_beat;
                        addr_reg    <= '0;
                        // read regs still hold an old slot; slot 0 lands next cycle
                        rd_ok_reg   <= 1'b0;
                        hit_reg     <= 1'b0;
                        best_reg    <= 1'b0;
                        free_ok_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN, S_DRAIN, S_SCAN2, S_DRAIN2:
                begin
                    // compare slot on the read regs
                    if (rd_ok_reg && state_reg != S_DRAIN2)
                    begin
                        if (rd_valid && key_eq && !hit_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= raddr_reg;
                            hit_pkt_reg  <= rd_pkt_reg;
                        end
                        if (rd_valid && earlier)
                        begin
                            best_reg      <= 1'b1;
                            best_slot_reg <= raddr_reg;
                            best_dl_reg   <= rd_dl_reg;
                            best_pkt_reg  <= rd_pkt_reg;
                        end
                        if (!valid_reg[raddr_reg] && !free_ok_reg)
                        begin
                            free_ok_reg   <= 1'b1;
                            free_slot_reg <= raddr_reg;
                        end
                    end
                    if (state_reg == S_SCAN)
                    begin
                        rd_ok_reg <= 1'b1;
                        if (addr_reg == AW'(DEPTH - 1))
                            state_reg <= S_DRAIN;
                        else
                            addr_reg <= addr_reg + 1'b1;
                    end
                    else if (state_reg == S_DRAIN)
                    begin
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                    else if (state_reg == S_DRAIN2)
                    begin
                        // evicted slot reused as the lowest free one
                        valid_reg[free_slot_reg] <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DRAIN2;
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    res_reg   <= '{result_index: 16'd0, status: ST_NONE};
                    unique case (req_reg.func)
                        FUNC_LOOKUP:
                            if (hit_reg)
                                res_reg <= '{result_index: hit_pkt_reg, status: ST_HIT};
                        FUNC_MATCH:
                            if (hit_reg)
                            begin
                                res_reg <= '{result_index: hit_pkt_reg, status: ST_HIT};
                                valid_reg[hit_slot_reg] <= 1'b0;
                                used_reg <= used_reg - 1'b1;
                            end
                        FUNC_EXPIRE:
                            if (best_reg && best_dl_reg <= req_reg.now)
                            begin
                                res_reg <= '{result_index: best_pkt_reg, status: ST_HIT};
                                valid_reg[best_slot_reg] <= 1'b0;
                                used_reg <= used_reg - 1'b1;
                            end
                        FUNC_SAVE:
                            if (hit_reg)
                                res_reg <= '{result_index: 16'd0, status: ST_DUP};
                            else if (used_reg == CW'(DEPTH))
                            begin
                                // full: evict earliest; it is the lowest free slot then
                                res_reg <= '{result_index: best_pkt_reg, status: ST_EVICTED};
                                valid_reg[best_slot_reg] <= 1'b0;
                                free_slot_reg <= best_slot_reg;
                                state_reg <= S_SCAN2;
                            end
                            else
                            begin
                                res_reg <= '{result_index: 16'd0, status: ST_SAVED};
                                valid_reg[free_slot_reg] <= 1'b1;
                                used_reg <= used_reg + 1'b1;
                            end
                        default: ;
                    endcase
                end
                S_OUT:
                begin
                    // output register changes only once the earlier beat is gone
                    if (!out_valid_reg)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
